// File: src/vri_pkg.sv
// Shared types, codes and constants of the vehicle remote interlock block.
package vri_pkg;

  // Default width of the remote-start run-time counter.
  localparam int unsigned RunCountBitsDef = 24;

  // Configuration port geometry and register widths.
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 24;
  localparam int unsigned FeatureW      = 4;
  localparam int unsigned MaxRunW       = 24;
  localparam int unsigned SpeedW        = 12;

  // Reset values of the configuration registers.
  localparam logic [FeatureW-1:0] FeatureRst    = 4'd15;
  localparam logic [MaxRunW-1:0]  MaxRunRst     = 24'd600000;
  localparam logic [SpeedW-1:0]   StationaryRst = 12'd16;

  // Bit positions inside feature_enables.
  localparam int unsigned FeatHorn  = 0;
  localparam int unsigned FeatInd   = 1;
  localparam int unsigned FeatImm   = 2;
  localparam int unsigned FeatStart = 3;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FEATURE_ENABLES  = 2'd0,
    CFG_MAX_RUN_TICKS    = 2'd1,
    CFG_STATIONARY_LIMIT = 2'd2
  } cfg_idx_e;

  // Command codes.
  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_HORN      = 3'd1,
    ACT_HAZARD    = 3'd2,
    ACT_INDICATOR = 3'd3,
    ACT_LOCK      = 3'd4,
    ACT_START     = 3'd5,
    ACT_STOP      = 3'd6
  } action_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MOVING   = 3'd1,
    ST_ENGINE   = 3'd2,
    ST_NEUTRAL  = 3'd3,
    ST_STAND    = 3'd4,
    ST_ACTIVE   = 3'd5,
    ST_DISABLED = 3'd6,
    ST_KILL     = 3'd7
  } status_e;

  // Reasons for ending a remote-started run.
  typedef enum logic [2:0] {
    CUT_NONE    = 3'd0,
    CUT_GEAR    = 3'd1,
    CUT_STAND   = 3'd2,
    CUT_MOTION  = 3'd3,
    CUT_KILL    = 3'd4,
    CUT_TIMEOUT = 3'd5,
    CUT_APP     = 3'd6
  } cut_e;

  // Command word: one command with a vehicle status snapshot.
  typedef struct packed {
    logic [2:0]        action;
    logic              switch_on;
    logic              left_side;
    logic              in_neutral;
    logic              stand_down;
    logic              kill_engaged;
    logic              engine_running;
    logic [SpeedW-1:0] speed;
  } cmd_t;

  // Result word: status and relay levels after the command.
  typedef struct packed {
    logic [2:0] status_code;
    logic       horn_relay;
    logic       left_relay;
    logic       right_relay;
    logic       immobilizer_relay;
    logic       starter_pulse;
    logic       start_active;
    logic [2:0] cut_reason;
  } res_t;

endpackage

// File: src/vri_if.sv
// Valid/ready channel interfaces for command and result words.
interface vri_cmd_if
  import vri_pkg::*;
();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vri_res_if
  import vri_pkg::*;
();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/vehicle_remote_interlock_top.sv
// A result word is registered and appears in the cycle after its command word is accepted.
// Throughput: one command word per cycle; the single result register is refilled
// in the same cycle that its word is taken, so stalls only come from the result side.
// Reset (rst_ni low, asynchronous): relays off, unlocked, no run active, counter
// cleared, configuration registers back to their defaults, no result pending.
module vehicle_remote_interlock_top
  import vri_pkg::*;
#(
  parameter int unsigned RUN_COUNT_BITS = RunCountBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  vri_cmd_if.sink             cmd_i,
  vri_res_if.source           res_o
);

  localparam int unsigned CmpW = (RUN_COUNT_BITS > MaxRunW) ? RUN_COUNT_BITS : MaxRunW;
  localparam logic [RUN_COUNT_BITS-1:0] CountTop = {RUN_COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [FeatureW-1:0] feature_q;
  logic [MaxRunW-1:0]  max_run_q;
  logic [SpeedW-1:0]   stat_limit_q;

  // Block state.
  logic                      horn_q, horn_d;
  logic                      left_q, left_d;
  logic                      right_q, right_d;
  logic                      lock_q, lock_d;
  logic                      run_q, run_d;
  logic [RUN_COUNT_BITS-1:0] count_q, count_d;

  // Result register.
  logic    res_valid_q;
  res_t    res_q;
  status_e status_d;
  cut_e    cut_d;
  logic    pulse_d;

  logic    cmd_acc;
  logic    stationary;
  cmd_t    cmd;
  action_e act;
  logic    en_horn, en_ind, en_imm, en_start;

  assign cmd        = cmd_i.data;
  assign act        = action_e'(cmd.action);
  assign stationary = cmd.speed < stat_limit_q;
  assign en_horn    = feature_q[FeatHorn];
  assign en_ind     = feature_q[FeatInd];
  assign en_imm     = feature_q[FeatImm];
  assign en_start   = feature_q[FeatStart];

  // A new word is taken whenever the result register is empty or being drained.
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_q    <= FeatureRst;
      max_run_q    <= MaxRunRst;
      stat_limit_q <= StationaryRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FEATURE_ENABLES:  feature_q    <= cfg_wdata_i[FeatureW-1:0];
        CFG_MAX_RUN_TICKS:    max_run_q    <= cfg_wdata_i[MaxRunW-1:0];
        CFG_STATIONARY_LIMIT: stat_limit_q <= cfg_wdata_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Command decode, interlock checks and next state.
  always_comb begin
    logic [RUN_COUNT_BITS-1:0] cnt_inc;
    horn_d   = horn_q;
    left_d   = left_q;
    right_d  = right_q;
    lock_d   = lock_q;
    run_d    = run_q;
    count_d  = count_q;
    status_d = ST_OK;
    cut_d    = CUT_NONE;
    pulse_d  = 1'b0;
    cnt_inc  = (count_q != CountTop) ? count_q + 1'b1 : count_q;
    case (act)
      ACT_TICK: begin
        if (en_start && run_q) begin
          count_d = cnt_inc;
          if (!cmd.in_neutral)                             cut_d = CUT_GEAR;
          else if (!cmd.stand_down)                        cut_d = CUT_STAND;
          else if (!stationary)                            cut_d = CUT_MOTION;
          else if (cmd.kill_engaged)                       cut_d = CUT_KILL;
          else if (CmpW'(cnt_inc) > CmpW'(max_run_q))      cut_d = CUT_TIMEOUT;
          if (cut_d != CUT_NONE) run_d = 1'b0;
        end
      end
      ACT_HORN: begin
        if (!en_horn) status_d = ST_DISABLED;
        else          horn_d   = cmd.switch_on;
      end
      ACT_HAZARD: begin
        if (!en_ind) begin
          status_d = ST_DISABLED;
        end else begin
          left_d  = cmd.switch_on;
          right_d = cmd.switch_on;
        end
      end
      ACT_INDICATOR: begin
        if (!en_ind)            status_d = ST_DISABLED;
        else if (!stationary)   status_d = ST_MOVING;
        else if (cmd.left_side) left_d   = cmd.switch_on;
        else                    right_d  = cmd.switch_on;
      end
      ACT_LOCK: begin
        if (!en_imm)                 status_d = ST_DISABLED;
        else if (!cmd.switch_on)     lock_d   = 1'b0;
        else if (cmd.engine_running) status_d = ST_ENGINE;
        else if (!stationary)        status_d = ST_MOVING;
        else                         lock_d   = 1'b1;
      end
      ACT_START: begin
        if (!en_start)               status_d = ST_DISABLED;
        else if (run_q)              status_d = ST_ACTIVE;
        else if (cmd.engine_running) status_d = ST_ENGINE;
        else if (!cmd.in_neutral)    status_d = ST_NEUTRAL;
        else if (!cmd.stand_down)    status_d = ST_STAND;
        else if (cmd.kill_engaged)   status_d = ST_KILL;
        else begin
          pulse_d = 1'b1;
          run_d   = 1'b1;
          count_d = '0;
        end
      end
      ACT_STOP: begin
        if (!en_start) begin
          status_d = ST_DISABLED;
        end else begin
          run_d = 1'b0;
          cut_d = CUT_APP;
        end
      end
      default: ;
    endcase
  end

  // State registers update only on an accepted command word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horn_q  <= 1'b0;
      left_q  <= 1'b0;
      right_q <= 1'b0;
      lock_q  <= 1'b0;
      run_q   <= 1'b0;
      count_q <= '0;
    end else if (cmd_acc) begin
      horn_q  <= horn_d;
      left_q  <= left_d;
      right_q <= right_d;
      lock_q  <= lock_d;
      run_q   <= run_d;
      count_q <= count_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      res_valid_q <= cmd_i.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      res_q.status_code       <= status_d;
      res_q.horn_relay        <= horn_d;
      res_q.left_relay        <= left_d;
      res_q.right_relay       <= right_d;
      res_q.immobilizer_relay <= lock_d;
      res_q.starter_pulse     <= pulse_d;
      res_q.start_active      <= run_d;
      res_q.cut_reason        <= cut_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // A starter pulse request only comes with a clean start that leaves a run active.
  a_pulse_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.starter_pulse) |->
      (res_q.start_active && res_q.status_code == ST_OK && res_q.cut_reason == CUT_NONE))
    else $error("starter pulse without a clean start");

  // A cut always leaves the run inactive.
  a_cut_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.cut_reason != CUT_NONE) |-> !res_q.start_active)
    else $error("run still active after a cut");

  // A run can only begin through an accepted start command.
  a_run_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> $past(cmd_acc && act == ACT_START))
    else $error("run became active without a start command");

  // The run-time counter only moves while a run is active or restarts at zero.
  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(run_q) && !run_q) |-> $stable(count_q))
    else $error("run counter changed with no run active");

endmodule
